// File: sv/sprq_pkg.sv
// shared types, constants and helpers of the strict priority request queue
package sprq_pkg;

  localparam int CLS_MAX      = 16;
  localparam int POOL         = 1024;
  localparam int CLS_W        = $clog2(CLS_MAX);
  localparam int PTR_W        = $clog2(POOL);
  localparam int CNT_W        = $clog2(POOL + 1);
  localparam int BUF_W        = 16;
  localparam int QP_W         = 24;
  localparam int PRIO_W       = 8;
  localparam int SPRIO_W      = 4;
  localparam int CFG_W        = 5;
  localparam int PAY_W        = BUF_W + QP_W;
  localparam int IN_DATA_W    = 48;
  localparam int OUT_DATA_W   = 48;
  localparam int OUT_FIELDS_W = BUF_W + QP_W + SPRIO_W;

  localparam logic [CFG_W-1:0] NPRIO_RESET = 5'd16;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BAD_PRIO = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  typedef logic [PTR_W-1:0] ptr_t;

  typedef struct packed {
    logic             pay_we;
    ptr_t             pay_waddr;
    logic [PAY_W-1:0] pay_wdata;
    logic             pay_re;
    ptr_t             pay_raddr;
    logic             nxt_we;
    ptr_t             nxt_waddr;
    ptr_t             nxt_wdata;
    logic             nxt_re;
    ptr_t             nxt_raddr;
  } mem_req_t;

  typedef struct packed {
    status_e            status;
    logic [BUF_W-1:0]   buffer_id;
    logic [QP_W-1:0]    source_qp;
    logic [SPRIO_W-1:0] priority_cls;
  } result_t;

  // lowest set bit of the class mask
  function automatic logic [CLS_W-1:0] first_set(input logic [CLS_MAX-1:0] v);
    logic [CLS_W-1:0] idx;
    idx = '0;
    for (int i = CLS_MAX - 1; i >= 0; i--) begin
      if (v[i]) idx = CLS_W'(i);
    end
    return idx;
  endfunction

endpackage

// File: sv/sprq_ram.sv
// generic single write port, single read port ram with registered read
module sprq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/sprq_seq.sv
// sequencer with class tables, free list pointers and result register
module sprq_seq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          in_mode_i,
  input  logic [sprq_pkg::BUF_W-1:0]    in_buffer_id_i,
  input  logic [sprq_pkg::QP_W-1:0]     in_source_qp_i,
  input  logic [sprq_pkg::PRIO_W-1:0]   in_priority_i,
  input  logic [sprq_pkg::CFG_W-1:0]    num_prio_i,
  output sprq_pkg::mem_req_t            mem_o,
  input  logic [sprq_pkg::PAY_W-1:0]    pay_rdata_i,
  input  sprq_pkg::ptr_t                nxt_rdata_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output sprq_pkg::result_t             out_res_o
);

  typedef enum logic {S_IDLE, S_EXEC} state_e;

  state_e                          state_q;
  logic [sprq_pkg::CLS_MAX-1:0]    nonempty_q;
  sprq_pkg::ptr_t                  head_q [sprq_pkg::CLS_MAX];
  sprq_pkg::ptr_t                  tail_q [sprq_pkg::CLS_MAX];
  sprq_pkg::ptr_t                  free_head_q;
  logic [sprq_pkg::CNT_W-1:0]      used_q;
  logic [sprq_pkg::CNT_W-1:0]      mark_q;
  logic                            op_mode_q;
  sprq_pkg::status_e               op_status_q;
  sprq_pkg::ptr_t                  op_slot_q;
  logic [sprq_pkg::CLS_W-1:0]      op_cls_q;
  logic                            op_drain_q;
  sprq_pkg::ptr_t                  fh_save_q;
  logic                            unwr_q;
  sprq_pkg::ptr_t                  succ_q;
  logic                            out_valid_q;
  sprq_pkg::result_t               out_res_q;
  sprq_pkg::result_t               out_res_d;

  logic                            accept;
  logic                            prio_ok;
  logic                            full;
  logic [sprq_pkg::CLS_W-1:0]      enq_cls;
  logic                            any;
  logic [sprq_pkg::CLS_W-1:0]      srv_cls;
  sprq_pkg::ptr_t                  srv_slot;
  logic                            drain;
  logic                            enq_go;
  logic                            srv_go;
  sprq_pkg::ptr_t                  rd_addr;
  sprq_pkg::status_e               acc_status;
  sprq_pkg::ptr_t                  nxt_val;
  logic                            exec_fire;
  logic                            exec_ok;

  always_comb begin
    accept    = in_valid_i && (state_q == S_IDLE);
    prio_ok   = ({1'b0, in_priority_i} < (sprq_pkg::PRIO_W + 1)'(num_prio_i)) &&
                ({1'b0, in_priority_i} < (sprq_pkg::PRIO_W + 1)'(sprq_pkg::CLS_MAX));
    full      = (used_q == sprq_pkg::CNT_W'(sprq_pkg::POOL));
    enq_cls   = in_priority_i[sprq_pkg::CLS_W-1:0];
    any       = |nonempty_q;
    srv_cls   = sprq_pkg::first_set(nonempty_q);
    srv_slot  = head_q[srv_cls];
    drain     = (srv_slot == tail_q[srv_cls]);
    enq_go    = accept && !in_mode_i && prio_ok && !full;
    srv_go    = accept && in_mode_i && any;
    rd_addr   = in_mode_i ? srv_slot : free_head_q;
    if (in_mode_i) begin
      acc_status = any ? sprq_pkg::ST_OK : sprq_pkg::ST_EMPTY;
    end else if (!prio_ok) begin
      acc_status = sprq_pkg::ST_BAD_PRIO;
    end else if (full) begin
      acc_status = sprq_pkg::ST_FULL;
    end else begin
      acc_status = sprq_pkg::ST_OK;
    end
    // never written entries still hold the initial index order chain
    nxt_val   = unwr_q ? succ_q : nxt_rdata_i;
    exec_fire = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);
    exec_ok   = exec_fire && (op_status_q == sprq_pkg::ST_OK);
  end

  always_comb begin
    out_res_d        = '0;
    out_res_d.status = op_status_q;
    if (op_mode_q && (op_status_q == sprq_pkg::ST_OK)) begin
      out_res_d.buffer_id    = pay_rdata_i[sprq_pkg::BUF_W-1:0];
      out_res_d.source_qp    = pay_rdata_i[sprq_pkg::PAY_W-1:sprq_pkg::BUF_W];
      out_res_d.priority_cls = sprq_pkg::SPRIO_W'(op_cls_q);
    end
  end

  always_comb begin
    mem_o           = '0;
    mem_o.pay_we    = enq_go;
    mem_o.pay_waddr = free_head_q;
    mem_o.pay_wdata = {in_source_qp_i, in_buffer_id_i};
    mem_o.pay_re    = srv_go;
    mem_o.pay_raddr = srv_slot;
    mem_o.nxt_re    = enq_go || srv_go;
    mem_o.nxt_raddr = rd_addr;
    if (enq_go && nonempty_q[enq_cls]) begin
      mem_o.nxt_we    = 1'b1;
      mem_o.nxt_waddr = tail_q[enq_cls];
      mem_o.nxt_wdata = free_head_q;
    end else if (exec_ok && op_mode_q) begin
      mem_o.nxt_we    = 1'b1;
      mem_o.nxt_waddr = op_slot_q;
      mem_o.nxt_wdata = fh_save_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      nonempty_q  <= '0;
      for (int i = 0; i < sprq_pkg::CLS_MAX; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
      end
      free_head_q <= '0;
      used_q      <= '0;
      mark_q      <= '0;
      op_mode_q   <= 1'b0;
      op_status_q <= sprq_pkg::ST_OK;
      op_slot_q   <= '0;
      op_cls_q    <= '0;
      op_drain_q  <= 1'b0;
      fh_save_q   <= '0;
      unwr_q      <= 1'b0;
      succ_q      <= '0;
      out_valid_q <= 1'b0;
      out_res_q   <= '0;
    end else begin
      if (accept) begin
        state_q     <= S_EXEC;
        op_mode_q   <= in_mode_i;
        op_status_q <= acc_status;
        op_slot_q   <= rd_addr;
        op_cls_q    <= in_mode_i ? srv_cls : enq_cls;
        op_drain_q  <= drain;
        unwr_q      <= ({1'b0, rd_addr} >= mark_q);
        succ_q      <= (rd_addr == sprq_pkg::PTR_W'(sprq_pkg::POOL - 1)) ? '0 :
                       rd_addr + sprq_pkg::PTR_W'(1);
      end
      if (enq_go) begin
        if (!nonempty_q[enq_cls]) head_q[enq_cls] <= free_head_q;
        tail_q[enq_cls]     <= free_head_q;
        nonempty_q[enq_cls] <= 1'b1;
        used_q              <= used_q + sprq_pkg::CNT_W'(1);
      end
      if (srv_go) begin
        if (drain) nonempty_q[srv_cls] <= 1'b0;
        fh_save_q   <= free_head_q;
        free_head_q <= srv_slot;
        used_q      <= used_q - sprq_pkg::CNT_W'(1);
      end
      if (exec_ok && !op_mode_q) begin
        free_head_q <= nxt_val;
        if ({1'b0, op_slot_q} == mark_q) mark_q <= mark_q + sprq_pkg::CNT_W'(1);
      end
      if (exec_ok && op_mode_q && !op_drain_q) begin
        head_q[op_cls_q] <= nxt_val;
      end
      if (exec_fire) begin
        state_q     <= S_IDLE;
        out_valid_q <= 1'b1;
        out_res_q   <= out_res_d;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

  a_used_le_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (used_q <= mark_q))
    else $error("more entries in use than ever allocated");

  a_mark_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mark_q <= sprq_pkg::CNT_W'(sprq_pkg::POOL)) else $error("fill mark past pool");

  a_empty_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_q == '0) |-> (nonempty_q == '0)) else $error("class marked with empty pool");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_EXEC)) else $error("accepted item not executed");

  a_no_fire_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i && state_q == S_EXEC) |=> $stable(out_res_q))
    else $error("pending result overwritten");

endmodule

// File: sv/strict_priority_request_queue_core.sv
// top level of the strict priority request queue with shared entry pool
//
// channel   direction  tdata                                      tuser
// s_axis    in         buffer_id[15:0] source_qp[39:16] prio[47:40] mode
// m_axis    out        buffer_id[15:0] source_qp[39:16] prio[43:40] status
// cfg       in         num_priorities[4:0] on cfg_we_i            -
//
// each item is accepted in S_IDLE and finished in S_EXEC; a serve reads the link and payload
// rams on accept, an enqueue writes the payload and the tail link and reads the free link;
// S_EXEC writes a served link back or advances the free head and loads the result register;
// no new item is taken before that, and a held result holds S_EXEC until m_axis_tready_i
// reset takes effect at once: the free chain is tracked by a fill mark, no clearing pass
module strict_priority_request_queue_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [sprq_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,  // buffer_id, source_qp, priority_req
  input  logic                              s_axis_tuser_i,  // mode
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [sprq_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o,  // buffer_id, source_qp, priority
  output logic [1:0]                        m_axis_tuser_o,  // status
  input  logic                              cfg_we_i,
  input  logic [sprq_pkg::CFG_W-1:0]        cfg_wdata_i
);

  logic [sprq_pkg::CFG_W-1:0] nprio_q;
  sprq_pkg::mem_req_t         mem_req;
  logic [sprq_pkg::PAY_W-1:0] pay_rdata;
  sprq_pkg::ptr_t             nxt_rdata;
  sprq_pkg::result_t          res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nprio_q <= sprq_pkg::NPRIO_RESET;
    end else if (cfg_we_i) begin
      nprio_q <= cfg_wdata_i;
    end
  end

  sprq_ram #(
    .WIDTH (sprq_pkg::PAY_W),
    .DEPTH (sprq_pkg::POOL)
  ) u_pay_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.pay_we),
    .waddr_i (mem_req.pay_waddr),
    .wdata_i (mem_req.pay_wdata),
    .re_i    (mem_req.pay_re),
    .raddr_i (mem_req.pay_raddr),
    .rdata_o (pay_rdata)
  );

  sprq_ram #(
    .WIDTH (sprq_pkg::PTR_W),
    .DEPTH (sprq_pkg::POOL)
  ) u_nxt_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.nxt_we),
    .waddr_i (mem_req.nxt_waddr),
    .wdata_i (mem_req.nxt_wdata),
    .re_i    (mem_req.nxt_re),
    .raddr_i (mem_req.nxt_raddr),
    .rdata_o (nxt_rdata)
  );

  sprq_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid_i),
    .in_ready_o     (s_axis_tready_o),
    .in_mode_i      (s_axis_tuser_i),
    .in_buffer_id_i (s_axis_tdata_i[15:0]),
    .in_source_qp_i (s_axis_tdata_i[39:16]),
    .in_priority_i  (s_axis_tdata_i[47:40]),
    .num_prio_i     (nprio_q),
    .mem_o          (mem_req),
    .pay_rdata_i    (pay_rdata),
    .nxt_rdata_i    (nxt_rdata),
    .out_valid_o    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .out_res_o      (res)
  );

  assign m_axis_tdata_o = {{(sprq_pkg::OUT_DATA_W - sprq_pkg::OUT_FIELDS_W){1'b0}},
                           res.priority_cls, res.source_qp, res.buffer_id};
  assign m_axis_tuser_o = res.status;

endmodule

// File: tb/strict_priority_request_queue_core_tb.sv
// self-checking testbench of the strict priority request queue core with a per-class queue predictor
`timescale 1ns / 1ps

module strict_priority_request_queue_core_tb;
  import sprq_pkg::*;

  localparam logic MODE_ENQ   = 1'b0;
  localparam logic MODE_SERVE = 1'b1;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i;   // buffer_id, source_qp, priority_req
  logic                  s_axis_tuser_i;   // mode
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;   // buffer_id, source_qp, priority
  logic [1:0]            m_axis_tuser_o;   // status
  logic                  cfg_we_i;
  logic [CFG_W-1:0]      cfg_wdata_i;

  // queue predictor state
  logic [PAY_W-1:0]   q_payload [POOL];
  ptr_t               q_link [POOL];
  ptr_t               q_head [CLS_MAX];
  ptr_t               q_tail [CLS_MAX];
  logic [CLS_MAX-1:0] q_busy;
  ptr_t               q_free;
  int unsigned        q_used;
  logic [CFG_W-1:0]   q_nprio;

  result_t pending_responses[$];
  result_t seen_resp;
  result_t want_resp;
  int      mismatches = 0;
  bit      src_idle_en = 1'b1;
  bit      snk_idle_en = 1'b1;

  strict_priority_request_queue_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void queue_reset();
    for (int i = 0; i < POOL; i++) begin
      q_payload[i] = '0;
      q_link[i]    = ptr_t'((i + 1) % POOL);
    end
    for (int c = 0; c < CLS_MAX; c++) begin
      q_head[c] = '0;
      q_tail[c] = '0;
    end
    q_busy  = '0;
    q_free  = '0;
    q_used  = 0;
    q_nprio = NPRIO_RESET;
  endfunction

  function automatic result_t predict_response(input logic mode, input logic [BUF_W-1:0] bid,
                                               input logic [QP_W-1:0] qp,
                                               input logic [PRIO_W-1:0] prio);
    result_t     r;
    int          cls;
    int unsigned lim;
    ptr_t        slot;
    r = '0;
    r.status = ST_OK;
    if (mode == MODE_SERVE) begin
      cls = -1;
      for (int i = CLS_MAX - 1; i >= 0; i--) begin
        if (q_busy[i]) cls = i;
      end
      if (cls < 0) begin
        r.status = ST_EMPTY;
      end else begin
        slot = q_head[cls];
        if (slot == q_tail[cls]) q_busy[cls] = 1'b0;
        else q_head[cls] = q_link[slot];
        q_link[slot] = q_free;
        q_free = slot;
        q_used--;
        r.buffer_id    = q_payload[slot][BUF_W-1:0];
        r.source_qp    = q_payload[slot][PAY_W-1:BUF_W];
        r.priority_cls = SPRIO_W'(cls);
      end
    end else begin
      lim = (q_nprio > CLS_MAX) ? CLS_MAX : q_nprio;
      if (prio >= lim) begin
        r.status = ST_BAD_PRIO;
      end else if (q_used >= POOL) begin
        r.status = ST_FULL;
      end else begin
        cls = prio;
        slot = q_free;
        q_free = q_link[slot];
        q_payload[slot] = {qp, bid};
        if (q_busy[cls]) q_link[q_tail[cls]] = slot;
        else q_head[cls] = slot;
        q_tail[cls] = slot;
        q_busy[cls] = 1'b1;
        q_used++;
      end
    end
    return r;
  endfunction

  task automatic flag_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      seen_resp.status       = status_e'(m_axis_tuser_o);
      seen_resp.buffer_id    = m_axis_tdata_o[BUF_W-1:0];
      seen_resp.source_qp    = m_axis_tdata_o[PAY_W-1:BUF_W];
      seen_resp.priority_cls = m_axis_tdata_o[PAY_W+SPRIO_W-1:PAY_W];
      if (pending_responses.size() == 0) begin
        flag_error($sformatf("unexpected item: status %0d buf %h qp %h cls %0d",
                             seen_resp.status, seen_resp.buffer_id, seen_resp.source_qp,
                             seen_resp.priority_cls));
      end else begin
        want_resp = pending_responses[0];
        pending_responses.delete(0);
        if (seen_resp.status !== want_resp.status ||
            seen_resp.buffer_id !== want_resp.buffer_id ||
            seen_resp.source_qp !== want_resp.source_qp ||
            seen_resp.priority_cls !== want_resp.priority_cls) begin
          flag_error($sformatf(
            "expected status %0d buf %h qp %h cls %0d, got status %0d buf %h qp %h cls %0d",
            want_resp.status, want_resp.buffer_id, want_resp.source_qp,
            want_resp.priority_cls, seen_resp.status, seen_resp.buffer_id,
            seen_resp.source_qp, seen_resp.priority_cls));
        end
      end
    end
  end

  // result side back-pressure
  initial begin
    m_axis_tready_i <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (snk_idle_en && $urandom_range(0, 4) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  end

  task automatic send_item(input logic mode, input logic [BUF_W-1:0] bid,
                           input logic [QP_W-1:0] qp, input logic [PRIO_W-1:0] prio);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {prio, qp, bid};
    s_axis_tuser_i  <= mode;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    pending_responses.insert(pending_responses.size(), predict_response(mode, bid, qp, prio));
  endtask

  task automatic send_random_item(input int enq_weight);
    logic             mode;
    logic [PRIO_W-1:0] prio;
    int unsigned      lim;
    lim  = (q_nprio > CLS_MAX) ? CLS_MAX : q_nprio;
    mode = ($urandom_range(0, 99) < enq_weight) ? MODE_ENQ : MODE_SERVE;
    if (lim == 0 || $urandom_range(0, 9) == 0) prio = PRIO_W'($urandom_range(0, 255));
    else prio = PRIO_W'($urandom_range(0, lim - 1));
    send_item(mode, BUF_W'($urandom), QP_W'($urandom), prio);
  endtask

  task automatic wait_for_drain();
    s_axis_tvalid_i <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_class_count(input logic [CFG_W-1:0] value);
    wait_for_drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    q_nprio = value;
  endtask

  task automatic test_reset_state();
    send_item(MODE_SERVE, 16'h5a5a, 24'ha5a5a5, 8'hff);
    send_item(MODE_ENQ, 16'h0000, 24'h000000, 8'd0);
    send_item(MODE_ENQ, 16'hffff, 24'hffffff, 8'd15);
    send_item(MODE_ENQ, 16'h1234, 24'habcdef, 8'd16);
    send_item(MODE_ENQ, 16'h4321, 24'hfedcba, 8'd255);
    send_item(MODE_ENQ, 16'h8001, 24'h800001, 8'd15);
    repeat (4) send_item(MODE_SERVE, BUF_W'($urandom), QP_W'($urandom), PRIO_W'($urandom));
  endtask

  task automatic test_class_limits();
    write_class_count(5'd1);
    send_item(MODE_ENQ, 16'h0101, 24'h010101, 8'd0);
    send_item(MODE_ENQ, 16'h0202, 24'h020202, 8'd1);
    write_class_count(5'd0);
    send_item(MODE_ENQ, 16'h0303, 24'h030303, 8'd0);
    write_class_count(5'd31);
    send_item(MODE_ENQ, 16'h0404, 24'h040404, 8'd15);
    send_item(MODE_ENQ, 16'h0505, 24'h050505, 8'd16);
    write_class_count(5'd16);
    send_item(MODE_ENQ, 16'h0606, 24'h060606, 8'd12);
    send_item(MODE_ENQ, 16'h0707, 24'h070707, 8'd3);
    // classes above the lowered count still drain in order
    write_class_count(5'd2);
    repeat (5) send_item(MODE_SERVE, '0, '0, '0);
  endtask

  task automatic test_random_traffic();
    logic [CFG_W-1:0] counts [8];
    int               weight;
    counts = '{5'd16, 5'd3, 5'd31, 5'd1, 5'd0, 5'd9, 5'd16, 5'd16};
    counts[6] = CFG_W'($urandom_range(1, 16));
    counts[7] = CFG_W'($urandom_range(1, 16));
    foreach (counts[p]) begin
      write_class_count(counts[p]);
      weight = $urandom_range(40, 70);
      repeat (8) send_random_item(weight);
    end
  endtask

  task automatic test_pool_full();
    write_class_count(5'd16);
    while (q_used < POOL)
      send_item(MODE_ENQ, BUF_W'($urandom), QP_W'($urandom), PRIO_W'($urandom_range(0, 15)));
    repeat (3)
      send_item(MODE_ENQ, BUF_W'($urandom), QP_W'($urandom), PRIO_W'($urandom_range(0, 15)));
    // priority check wins over the full pool
    send_item(MODE_ENQ, 16'h9999, 24'h999999, 8'd200);
    repeat (20) begin
      if ($urandom_range(0, 9) == 0)
        send_item(MODE_ENQ, BUF_W'($urandom), QP_W'($urandom), PRIO_W'($urandom_range(0, 15)));
      send_item(MODE_SERVE, BUF_W'($urandom), QP_W'($urandom), PRIO_W'($urandom));
    end
  endtask

  task automatic test_no_idle();
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    write_class_count(5'd7);
    repeat (40) send_random_item(55);
  endtask

  initial begin
    queue_reset();
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_wdata_i     <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_state();
    test_class_limits();
    test_random_traffic();
    test_pool_full();
    test_no_idle();
    wait_for_drain();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && pending_responses.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
